@@ rtl/igfs_pkg.sv @@
package igfs_pkg;

    localparam int unsigned ADDR_W = 3;

    localparam logic [31:0] ALL_ONES          = 32'hFFFF_FFFF;
    localparam logic [7:0]  FRAME_GAP_DEFAULT = 8'd5;
    localparam logic [15:0] WINDOW_DEFAULT    = 16'd100;

    typedef enum logic
    {
        KIND_BYTE    = 1'b0,
        KIND_RESTART = 1'b1
    } kind_t;

    typedef enum logic [ADDR_W-3:0]
    {
        REG_FRAME_GAP = 1'b0,
        REG_WINDOW    = 1'b1
    } reg_index_t;

    typedef struct packed
    {
        logic [7:0]  frame_gap_ms;
        logic [15:0] window_ms;
    } cfg_t;

    typedef struct packed
    {
        kind_t       kind;
        logic [31:0] now_ms;
        logic [7:0]  data_byte;
    } item_t;

    typedef struct packed
    {
        logic [7:0]  relay_byte;
        logic        frame_closed;
        logic [31:0] closed_frame_len;
        logic [31:0] closed_gap_ms;
        logic [31:0] total_bytes;
        logic [31:0] total_frames;
        logic [31:0] peak_window_bytes;
        logic [31:0] min_frame_len;
        logic [31:0] max_frame_len;
        logic [31:0] min_gap_ms;
        logic [31:0] max_gap_ms;
    } result_t;

endpackage

@@ rtl/igfs_regs.sv @@
module igfs_regs
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [igfs_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output igfs_pkg::cfg_t              cfg
);

    logic [7:0]           frame_gap_reg;
    logic [15:0]          window_reg;
    logic                 wr_en;
    igfs_pkg::reg_index_t index;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign index  = igfs_pkg::reg_index_t'(paddr[igfs_pkg::ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_gap_reg <= igfs_pkg::FRAME_GAP_DEFAULT;
            window_reg    <= igfs_pkg::WINDOW_DEFAULT;
        end
        else if (wr_en)
        begin
            case (index)
                igfs_pkg::REG_FRAME_GAP: frame_gap_reg <= pwdata[7:0];
                igfs_pkg::REG_WINDOW:    window_reg    <= pwdata[15:0];
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            igfs_pkg::REG_FRAME_GAP: prdata = {24'd0, frame_gap_reg};
            igfs_pkg::REG_WINDOW:    prdata = {16'd0, window_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    assign cfg.frame_gap_ms = frame_gap_reg;
    assign cfg.window_ms    = window_reg;

endmodule

@@ rtl/igfs_core.sv @@
module igfs_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  igfs_pkg::item_t   item,
    input  igfs_pkg::cfg_t    cfg,
    output igfs_pkg::result_t res
);

    logic [31:0] last_time_reg,  last_time_next;
    logic        in_frame_reg,   in_frame_next;
    logic [31:0] cur_len_reg,    cur_len_next;
    logic [31:0] win_start_reg,  win_start_next;
    logic [31:0] win_bytes_reg,  win_bytes_next;
    logic [31:0] peak_reg,       peak_next;
    logic [31:0] byte_total_reg, byte_total_next;
    logic [31:0] frame_total_reg, frame_total_next;
    logic [31:0] len_min_reg,    len_min_next;
    logic [31:0] len_max_reg,    len_max_next;
    logic [31:0] gap_min_reg,    gap_min_next;
    logic [31:0] gap_max_reg,    gap_max_next;

    logic [31:0] win_elapsed;
    logic [31:0] gap;
    logic        roll;
    logic        close;
    logic [31:0] win_base;
    logic [31:0] len_base;

    always_comb
    begin
        win_elapsed = item.now_ms - win_start_reg;
        gap         = item.now_ms - last_time_reg;
        roll        = win_elapsed >= {16'd0, cfg.window_ms};
        close       = in_frame_reg && (gap > {24'd0, cfg.frame_gap_ms});
        win_base    = roll ? 32'd0 : win_bytes_reg;
        len_base    = close ? 32'd0 : cur_len_reg;

        last_time_next   = item.now_ms;
        in_frame_next    = 1'b1;
        cur_len_next     = len_base + 32'd1;
        win_start_next   = roll ? item.now_ms : win_start_reg;
        win_bytes_next   = win_base + 32'd1;
        peak_next        = (roll && (win_bytes_reg > peak_reg)) ? win_bytes_reg : peak_reg;
        byte_total_next  = byte_total_reg + 32'd1;
        frame_total_next = close ? frame_total_reg + 32'd1 : frame_total_reg;
        len_min_next     = len_min_reg;
        len_max_next     = len_max_reg;
        gap_min_next     = gap_min_reg;
        gap_max_next     = gap_max_reg;

        if (close)
        begin
            if (cur_len_reg != 32'd0)
            begin
                if (cur_len_reg > len_max_reg)
                begin
                    len_max_next = cur_len_reg;
                end
                if (cur_len_reg < len_min_reg)
                begin
                    len_min_next = cur_len_reg;
                end
            end
            if (gap > gap_max_reg)
            begin
                gap_max_next = gap;
            end
            if (gap < gap_min_reg)
            begin
                gap_min_next = gap;
            end
        end

        res.relay_byte       = item.data_byte;
        res.frame_closed     = close;
        res.closed_frame_len = close ? cur_len_reg : 32'd0;
        res.closed_gap_ms    = close ? gap : 32'd0;

        if (item.kind == igfs_pkg::KIND_RESTART)
        begin
            last_time_next       = item.now_ms;
            in_frame_next        = 1'b0;
            cur_len_next         = 32'd0;
            win_start_next       = item.now_ms;
            win_bytes_next       = 32'd0;
            peak_next            = 32'd0;
            byte_total_next      = 32'd0;
            frame_total_next     = 32'd0;
            len_min_next         = igfs_pkg::ALL_ONES;
            len_max_next         = 32'd0;
            gap_min_next         = igfs_pkg::ALL_ONES;
            gap_max_next         = 32'd0;
            res.relay_byte       = 8'd0;
            res.frame_closed     = 1'b0;
            res.closed_frame_len = 32'd0;
            res.closed_gap_ms    = 32'd0;
        end

        res.total_bytes       = byte_total_next;
        res.total_frames      = frame_total_next;
        res.peak_window_bytes = peak_next;
        res.min_frame_len     = len_min_next;
        res.max_frame_len     = len_max_next;
        res.min_gap_ms        = gap_min_next;
        res.max_gap_ms        = gap_max_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg   <= 32'd0;
            in_frame_reg    <= 1'b0;
            cur_len_reg     <= 32'd0;
            win_start_reg   <= 32'd0;
            win_bytes_reg   <= 32'd0;
            peak_reg        <= 32'd0;
            byte_total_reg  <= 32'd0;
            frame_total_reg <= 32'd0;
            len_min_reg     <= igfs_pkg::ALL_ONES;
            len_max_reg     <= 32'd0;
            gap_min_reg     <= igfs_pkg::ALL_ONES;
            gap_max_reg     <= 32'd0;
        end
        else if (fire)
        begin
            last_time_reg   <= last_time_next;
            in_frame_reg    <= in_frame_next;
            cur_len_reg     <= cur_len_next;
            win_start_reg   <= win_start_next;
            win_bytes_reg   <= win_bytes_next;
            peak_reg        <= peak_next;
            byte_total_reg  <= byte_total_next;
            frame_total_reg <= frame_total_next;
            len_min_reg     <= len_min_next;
            len_max_reg     <= len_max_next;
            gap_min_reg     <= gap_min_next;
            gap_max_reg     <= gap_max_next;
        end
    end

endmodule

@@ rtl/idle_gap_frame_statistics_unit.sv @@
// Idle-gap frame statistics unit: monitors a timestamped byte stream.
// Input stream (s_*): one request per byte arrival or restart. s_tuser is the
// kind (0 byte, 1 restart at now_ms); s_tdata carries now_ms and data_byte.
// Output stream (m_*): exactly one result per input request, in order. m_tuser
// flags that the byte closed the previous frame; m_tdata carries the relayed
// byte, the closed frame length and gap, and the running statistics.
// APB port: frame_gap_ms at address 0, window_ms at address 4; write only
// while the stream is idle.
// Pipeline: an accepted request is held in the input register, then its result
// in the result register. Throughput: one request per cycle while m_tready is
// high, set by the combinational statistics update between the two registers.
// Stall: while m_tready is low the result is held; the input register still
// takes one more request, then s_tready drops until the result is taken.
// Reset: empties both registers, restores the default gap and window settings
// and clears all statistics (minimums to all ones).
module idle_gap_frame_statistics_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [39:0]                 s_tdata,   // now_ms[31:0], data_byte[39:32]
    input  logic                        s_tuser,   // kind[0]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [295:0]                m_tdata,   // relay_byte, closed_frame_len,
                                                   // closed_gap_ms, total_bytes,
                                                   // total_frames, peak_window_bytes,
                                                   // min_frame_len, max_frame_len,
                                                   // min_gap_ms, max_gap_ms
    output logic                        m_tuser,   // frame_closed[0]
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [igfs_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    igfs_pkg::cfg_t    cfg;
    igfs_pkg::item_t   item_reg;
    igfs_pkg::result_t res;
    igfs_pkg::result_t res_reg;
    logic              in_valid_reg;
    logic              out_valid_reg;
    logic              advance;
    logic              fire;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    igfs_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    igfs_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.kind      <= igfs_pkg::kind_t'(s_tuser);
            item_reg.now_ms    <= s_tdata[31:0];
            item_reg.data_byte <= s_tdata[39:32];
        end
        if (fire)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.frame_closed;
    assign m_tdata  = {res_reg.max_gap_ms, res_reg.min_gap_ms, res_reg.max_frame_len,
                       res_reg.min_frame_len, res_reg.peak_window_bytes,
                       res_reg.total_frames, res_reg.total_bytes,
                       res_reg.closed_gap_ms, res_reg.closed_frame_len,
                       res_reg.relay_byte};

endmodule

@@ dv/idle_gap_frame_statistics_unit_tb.sv @@
module idle_gap_frame_statistics_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 4;

    logic                        clk;
    logic                        rst_n    = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [39:0]                 s_tdata  = '0;
    logic                        s_tuser  = 1'b0;
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [295:0]                m_tdata;
    logic                        m_tuser;
    logic                        psel     = 1'b0;
    logic                        penable  = 1'b0;
    logic                        pwrite   = 1'b0;
    logic [igfs_pkg::ADDR_W-1:0] paddr    = '0;
    logic [31:0]                 pwdata   = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    // frame statistics predictor state
    logic [7:0]          cfg_gap;
    logic [15:0]         cfg_window;
    logic [31:0]         last_stamp;
    logic                frame_open;
    logic [31:0]         run_len;
    logic [31:0]         win_start;
    logic [31:0]         win_count;
    logic [31:0]         win_peak;
    logic [31:0]         bytes_seen;
    logic [31:0]         frames_seen;
    logic [31:0]         len_min;
    logic [31:0]         len_max;
    logic [31:0]         gap_lo;
    logic [31:0]         gap_hi;

    igfs_pkg::result_t   pending_stats[$];
    int                  fail_count  = 0;
    int                  cycle_count = 0;
    int                  burst_left  = 0;
    bit                  gaps_on     = 1'b1;
    bit                  hold_request = 1'b0;
    logic [31:0]         stamp_ms    = '0;

    idle_gap_frame_statistics_unit dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic void clear_stats(logic [31:0] t);
        last_stamp  = t;
        frame_open  = 1'b0;
        run_len     = '0;
        win_start   = t;
        win_count   = '0;
        win_peak    = '0;
        bytes_seen  = '0;
        frames_seen = '0;
        len_min     = igfs_pkg::ALL_ONES;
        len_max     = '0;
        gap_lo      = igfs_pkg::ALL_ONES;
        gap_hi      = '0;
    endfunction

    function automatic igfs_pkg::result_t account_item(igfs_pkg::kind_t kind,
                                                       logic [31:0] now,
                                                       logic [7:0] data);
        igfs_pkg::result_t r;
        logic [31:0]       gap;
        r = '0;
        if (kind == igfs_pkg::KIND_RESTART)
        begin
            clear_stats(now);
        end
        else
        begin
            r.relay_byte = data;
            bytes_seen++;
            if (now - win_start >= {16'd0, cfg_window})
            begin
                if (win_count > win_peak)
                    win_peak = win_count;
                win_count = '0;
                win_start = now;
            end
            win_count++;
            gap = now - last_stamp;
            if (frame_open && gap > {24'd0, cfg_gap})
            begin
                r.frame_closed     = 1'b1;
                r.closed_frame_len = run_len;
                r.closed_gap_ms    = gap;
                if (run_len != 0)
                begin
                    if (run_len > len_max)
                        len_max = run_len;
                    if (run_len < len_min)
                        len_min = run_len;
                end
                if (gap > gap_hi)
                    gap_hi = gap;
                if (gap < gap_lo)
                    gap_lo = gap;
                frames_seen++;
                run_len = '0;
            end
            run_len++;
            frame_open = 1'b1;
            last_stamp = now;
        end
        r.total_bytes       = bytes_seen;
        r.total_frames      = frames_seen;
        r.peak_window_bytes = win_peak;
        r.min_frame_len     = len_min;
        r.max_frame_len     = len_max;
        r.min_gap_ms        = gap_lo;
        r.max_gap_ms        = gap_hi;
        return r;
    endfunction

    task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            fail_count++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        igfs_pkg::result_t want;
        if (m_tvalid && m_tready)
        begin
            if (pending_stats.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected result: expected none, actual %h", $time, m_tdata);
            end
            else
            begin
                want = pending_stats.pop_front();
                compare_field("relay_byte", want.relay_byte, m_tdata[7:0]);
                compare_field("frame_closed", want.frame_closed, m_tuser);
                compare_field("closed_frame_len", want.closed_frame_len, m_tdata[8 +: 32]);
                compare_field("closed_gap_ms", want.closed_gap_ms, m_tdata[40 +: 32]);
                compare_field("total_bytes", want.total_bytes, m_tdata[72 +: 32]);
                compare_field("total_frames", want.total_frames, m_tdata[104 +: 32]);
                compare_field("peak_window_bytes", want.peak_window_bytes,
                              m_tdata[136 +: 32]);
                compare_field("min_frame_len", want.min_frame_len, m_tdata[168 +: 32]);
                compare_field("max_frame_len", want.max_frame_len, m_tdata[200 +: 32]);
                compare_field("min_gap_ms", want.min_gap_ms, m_tdata[232 +: 32]);
                compare_field("max_gap_ms", want.max_gap_ms, m_tdata[264 +: 32]);
            end
        end
    end

    initial
    begin : receiver
        int         mode;
        int         mode_left;
        int         hold_left;
        logic [7:0] pattern;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        pattern   = 8'hFF;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(16, 96);
                pattern   = 8'($urandom_range(0, 255)) | 8'h01;
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (mode == 0)
            begin
                m_tready <= 1'b1;
            end
            else if (mode == 1)
            begin
                m_tready <= ($urandom_range(0, 2) != 0);
            end
            else
            begin
                m_tready <= pattern[0];
                pattern = {pattern[0], pattern[7:1]};
            end
        end
    end

    // enter and leave at a falling edge
    task automatic send_request(igfs_pkg::kind_t kind, logic [31:0] now, logic [7:0] data);
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {data, now};
        do
            @(posedge clk);
        while (!s_tready);
        pending_stats.push_back(account_item(kind, now, data));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_stats.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(igfs_pkg::reg_index_t idx, logic [31:0] value);
        logic [31:0] mask;
        mask = (idx == igfs_pkg::REG_FRAME_GAP) ? 32'h0000_00FF : 32'h0000_FFFF;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (idx == igfs_pkg::REG_FRAME_GAP)
            cfg_gap = value[7:0];
        else
            cfg_window = value[15:0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        compare_field(idx == igfs_pkg::REG_FRAME_GAP ? "frame_gap_ms readback"
                                                     : "window_ms readback",
                      value & mask, prdata & mask);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_config(logic [31:0] gap, logic [31:0] window);
        wait_drained();
        write_reg(igfs_pkg::REG_FRAME_GAP, gap);
        write_reg(igfs_pkg::REG_WINDOW, window);
    endtask

    task automatic test_default_framing();
        send_request(igfs_pkg::KIND_BYTE, 32'd0, 8'h00);
        send_request(igfs_pkg::KIND_BYTE, 32'd3, 8'hFF);
        // gap equal to threshold: hold frame open
        send_request(igfs_pkg::KIND_BYTE, 32'd8, 8'hA5);
        send_request(igfs_pkg::KIND_BYTE, 32'd14, 8'h5A);
        send_request(igfs_pkg::KIND_BYTE, 32'd14, 8'h01);
        // roll window and close frame
        send_request(igfs_pkg::KIND_BYTE, 32'd120, 8'h80);
        // timestamp steps back: huge gap
        send_request(igfs_pkg::KIND_BYTE, 32'd50, 8'h7F);
        send_request(igfs_pkg::KIND_RESTART, 32'hFFFF_FFF0, 8'hC3);
        send_request(igfs_pkg::KIND_BYTE, 32'hFFFF_FFFF, 8'h11);
        // wrap timestamp through zero
        send_request(igfs_pkg::KIND_BYTE, 32'h0000_0002, 8'h22);
        send_request(igfs_pkg::KIND_BYTE, 32'h0000_0010, 8'h44);
        send_request(igfs_pkg::KIND_RESTART, 32'd0, 8'h00);
        send_request(igfs_pkg::KIND_BYTE, 32'hFFFF_FFFF, 8'h99);
    endtask

    task automatic test_register_extremes();
        // zero window: roll on every byte
        set_config(32'd0, 32'd0);
        send_request(igfs_pkg::KIND_BYTE, 32'd1000, 8'h01);
        send_request(igfs_pkg::KIND_BYTE, 32'd1000, 8'h02);
        send_request(igfs_pkg::KIND_BYTE, 32'd1001, 8'h03);
        set_config(32'd255, 32'd65535);
        send_request(igfs_pkg::KIND_BYTE, 32'd2000, 8'h04);
        send_request(igfs_pkg::KIND_BYTE, 32'd2255, 8'h05);
        send_request(igfs_pkg::KIND_BYTE, 32'd2511, 8'h06);
        send_request(igfs_pkg::KIND_BYTE, 32'd2000 + 32'd65535, 8'h07);
    endtask

    task automatic test_random_traffic(int count);
        int pick;
        repeat (count)
        begin
            pick = $urandom_range(0, 199);
            if (pick < 3)
            begin
                stamp_ms = $urandom;
                send_request(igfs_pkg::KIND_RESTART, stamp_ms, 8'($urandom_range(0, 255)));
            end
            else
            begin
                if (pick < 8)
                    stamp_ms = stamp_ms - $urandom_range(1, 5000);
                else if (pick < 14)
                    stamp_ms = stamp_ms + $urandom;
                else if (pick < 40)
                    stamp_ms = stamp_ms + cfg_gap + $urandom_range(0, 1);
                else if (pick < 90)
                    stamp_ms = stamp_ms + $urandom_range(0, 2 * cfg_gap + 2);
                else
                    stamp_ms = stamp_ms + $urandom_range(0, cfg_gap);
                send_request(igfs_pkg::KIND_BYTE, stamp_ms, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: set_config(32'd5, 32'd100);
                1: set_config(32'd0, 32'd1);
                2: set_config(32'd255, 32'd65535);
                default: set_config($urandom_range(0, 40), $urandom_range(1, 300));
            endcase
            gaps_on = (phase % 3 != 1);
            test_random_traffic(240);
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_output_backpressure();
        set_config(32'd3, 32'd20);
        gaps_on      = 1'b0;
        hold_request = 1'b1;
        test_random_traffic(60);
        gaps_on = 1'b1;
    endtask

    initial
    begin
        cfg_gap    = igfs_pkg::FRAME_GAP_DEFAULT;
        cfg_window = igfs_pkg::WINDOW_DEFAULT;
        clear_stats('0);
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_default_framing();
        test_register_extremes();
        test_random_phases();
        test_output_backpressure();

        wait_drained();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
